// ===== rtl/byte_ring_buffer_fifo_assert.svh =====
// assertion macros for the checker file
`ifndef BYTE_RING_BUFFER_FIFO_ASSERT_SVH
`define BYTE_RING_BUFFER_FIFO_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BRBF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brbf check failed");

// next-cycle implication, clocked on clk, off during reset
`define BRBF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brbf check failed");

`endif

// ===== rtl/brbf_pkg.sv =====
package brbf_pkg;

    // fixed field widths
    localparam int DATA_W  = 8;
    localparam int CAP_W   = 7;
    localparam int COUNT_W = 7;
    localparam int FREE_W  = 6;

    // smallest capacity the register accepts
    localparam int CAP_MIN = 2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_PEEK  = 2'd2,
        OP_SKIP  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PEEK
    } state_t;

endpackage

// ===== rtl/byte_ring_buffer_fifo.sv =====
// Byte FIFO on a circular store of DEPTH bytes that keeps one slot empty, so
// capacity minus one bytes are usable. Each input word is one operation: write,
// read, peek or skip. Write and skip finish in the idle state, a read passes
// through ST_READ (the store has a registered read port); a peek uses ST_PEEK, one
// store read per byte with the next read overlapped with each output word. The
// block takes no new word while a read or peek is in progress. A result word
// sits in an output register, so a new operation is accepted in the same cycle
// that the previous result is taken. Writing the capacity register clears both
// pointers; capacity is clamped to the range 2 to DEPTH.
module byte_ring_buffer_fifo #(
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [brbf_pkg::CAP_W-1:0]   capacity,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [brbf_pkg::DATA_W-1:0]  byte_in,
    input  logic [brbf_pkg::COUNT_W-1:0] count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [brbf_pkg::DATA_W-1:0]  data_out,
    output logic                         data_valid,
    output logic                         ok,
    output logic [brbf_pkg::COUNT_W-1:0] done_count,
    output logic [brbf_pkg::FREE_W-1:0]  free_space,
    output logic                         is_empty,
    output logic                         last
);
    import brbf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       cap_reg, cap_next;
    logic [PW-1:0]       rp_reg, rp_next;
    logic [PW-1:0]       wp_reg, wp_next;
    logic [PW-1:0]       pk_ptr_reg, pk_ptr_next;
    logic [CW-1:0]       pk_n_reg, pk_n_next;
    logic [CW-1:0]       pk_idx_reg, pk_idx_next;
    logic                pk_ok_reg, pk_ok_next;

    logic                out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]   out_data_reg, out_data_next;
    logic                out_dv_reg, out_dv_next;
    logic                out_ok_reg, out_ok_next;
    logic [COUNT_W-1:0]  out_done_reg, out_done_next;
    logic                out_last_reg, out_last_next;

    logic [DATA_W-1:0]   mem [DEPTH];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_wr;
    logic                mem_rd;
    logic [PW-1:0]       rd_addr;

    logic                out_free;
    logic                accept;
    logic                empty;
    logic [CW-1:0]       used;
    logic [CW-1:0]       avail_n;
    logic                req_ok;
    logic [CW:0]         skip_sum;
    logic [PW-1:0]       rp_skip;
    logic [CW-1:0]       cap_clamped;
    logic                pk_last;
    opcode_t             op;

    // advance a pointer by one slot, wrapping at capacity
    function automatic logic [PW-1:0] step_ptr(input logic [PW-1:0] p,
                                               input logic [CW-1:0] cap);
        logic [CW-1:0] inc;
        inc = CW'(p) + CW'(1);
        return (inc >= cap) ? '0 : PW'(inc);
    endfunction

    // handshake; a register write waits until the result word is free or being taken
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = (state_reg == ST_IDLE) && out_free;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free && !cfg_valid);
    assign accept    = in_valid && !in_stall;
    assign op        = opcode_t'(opcode);

    // fill level and derived limits
    assign empty    = (rp_reg == wp_reg);
    assign used     = (wp_reg >= rp_reg) ? CW'(wp_reg) - CW'(rp_reg)
                                         : CW'(wp_reg) + cap_reg - CW'(rp_reg);
    assign req_ok   = (count <= COUNT_W'(used));
    assign avail_n  = req_ok ? CW'(count) : used;
    assign skip_sum = (CW+1)'(rp_reg) + (CW+1)'(avail_n);
    assign rp_skip  = (skip_sum >= (CW+1)'(cap_reg)) ? PW'(skip_sum - (CW+1)'(cap_reg))
                                                    : PW'(skip_sum);
    assign pk_last  = ((pk_idx_reg + CW'(1)) == pk_n_reg);

    // capacity clamp
    assign cap_clamped = (capacity < CAP_W'(CAP_MIN)) ? CW'(CAP_MIN) :
                         (capacity > CAP_W'(DEPTH))   ? CW'(DEPTH)   : CW'(capacity);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    if (op == OP_READ && !empty)
                        state_next = ST_READ;
                    else if (op == OP_PEEK && avail_n != '0)
                        state_next = ST_PEEK;
                end
            end
            ST_READ:
                state_next = ST_IDLE;
            ST_PEEK:
            begin
                if (out_free && pk_last)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath control and result words
    always_comb
    begin
        cap_next       = cap_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        pk_ptr_next    = pk_ptr_reg;
        pk_n_next      = pk_n_reg;
        pk_idx_next    = pk_idx_reg;
        pk_ok_next     = pk_ok_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        out_dv_next    = out_dv_reg;
        out_ok_next    = out_ok_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        mem_wr         = 1'b0;
        mem_rd         = 1'b0;
        rd_addr        = rp_reg;

        // capacity write clears the pointers
        if (cfg_valid && cfg_ready) begin
            cap_next = cap_clamped;
            rp_next  = '0;
            wp_next  = '0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    case (op)
                        OP_WRITE:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_dv_next    = 1'b0;
                            out_done_next  = '0;
                            out_last_next  = 1'b1;
                            out_ok_next    = (step_ptr(wp_reg, cap_reg) != rp_reg);
                            if (step_ptr(wp_reg, cap_reg) != rp_reg) begin
                                mem_wr  = 1'b1;
                                wp_next = step_ptr(wp_reg, cap_reg);
                            end
                        end
                        OP_READ:
                        begin
                            if (!empty) begin
                                mem_rd  = 1'b1;
                                rp_next = step_ptr(rp_reg, cap_reg);
                            end else begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_dv_next    = 1'b0;
                                out_ok_next    = 1'b0;
                                out_done_next  = '0;
                                out_last_next  = 1'b1;
                            end
                        end
                        OP_PEEK:
                        begin
                            if (avail_n == '0) begin
                                out_valid_next = 1'b1;
                                out_data_next  = '0;
                                out_dv_next    = 1'b0;
                                out_ok_next    = req_ok;
                                out_done_next  = '0;
                                out_last_next  = 1'b1;
                            end else begin
                                mem_rd      = 1'b1;
                                pk_ptr_next = step_ptr(rp_reg, cap_reg);
                                pk_n_next   = avail_n;
                                pk_idx_next = '0;
                                pk_ok_next  = req_ok;
                            end
                        end
                        OP_SKIP:
                        begin
                            rp_next        = rp_skip;
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                            out_dv_next    = 1'b0;
                            out_ok_next    = req_ok;
                            out_done_next  = COUNT_W'(avail_n);
                            out_last_next  = 1'b1;
                        end
                        default:
                        begin
                            out_valid_next = out_valid_reg && out_stall;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // output slot is free: it was free or taken when the read was accepted
                out_valid_next = 1'b1;
                out_data_next  = rd_data_reg;
                out_dv_next    = 1'b1;
                out_ok_next    = 1'b1;
                out_done_next  = '0;
                out_last_next  = 1'b1;
            end
            ST_PEEK:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data_reg;
                    out_dv_next    = 1'b1;
                    out_ok_next    = pk_ok_reg;
                    out_done_next  = COUNT_W'(pk_idx_reg + CW'(1));
                    out_last_next  = pk_last;
                    pk_idx_next    = pk_idx_reg + CW'(1);
                    // fetch the next byte while this one goes out
                    if (!pk_last) begin
                        mem_rd      = 1'b1;
                        rd_addr     = pk_ptr_reg;
                        pk_ptr_next = step_ptr(pk_ptr_reg, cap_reg);
                    end
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && out_stall;
            end
        endcase
    end

    // byte store with registered read
    always_ff @(posedge clk)
    begin
        if (mem_wr)
            mem[wp_reg] <= byte_in;
        if (mem_rd)
            rd_data_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CW'(DEPTH);
            rp_reg        <= '0;
            wp_reg        <= '0;
            pk_ptr_reg    <= '0;
            pk_n_reg      <= '0;
            pk_idx_reg    <= '0;
            pk_ok_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cap_reg       <= cap_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            pk_ptr_reg    <= pk_ptr_next;
            pk_n_reg      <= pk_n_next;
            pk_idx_reg    <= pk_idx_next;
            pk_ok_reg     <= pk_ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_dv_reg   <= out_dv_next;
        out_ok_reg   <= out_ok_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
    end

    // outputs; fill status follows the pointers, which hold while a word waits
    assign out_valid  = out_valid_reg;
    assign data_out   = out_data_reg;
    assign data_valid = out_dv_reg;
    assign ok         = out_ok_reg;
    assign done_count = out_done_reg;
    assign last       = out_last_reg;
    assign free_space = FREE_W'(cap_reg - CW'(1) - used);
    assign is_empty   = empty;

endmodule

// ===== rtl/brbf_checker.sv =====
`include "byte_ring_buffer_fifo_assert.svh"

module brbf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_valid,
    input logic                         cfg_ready,
    input logic [brbf_pkg::CAP_W-1:0]   capacity,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [1:0]                   opcode,
    input logic [brbf_pkg::DATA_W-1:0]  byte_in,
    input logic [brbf_pkg::COUNT_W-1:0] count,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [brbf_pkg::DATA_W-1:0]  data_out,
    input logic                         data_valid,
    input logic                         ok,
    input logic [brbf_pkg::COUNT_W-1:0] done_count,
    input logic [brbf_pkg::FREE_W-1:0]  free_space,
    input logic                         is_empty,
    input logic                         last
);
    import brbf_pkg::*;

    // a stalled result word holds
    `BRBF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(data_out) && $stable(last))

    // a word with no byte carries zero data
    `BRBF_ASSERT_NOW(a_no_data_zero, out_valid && !data_valid, data_out == '0)

    // only peek emits more than one word, and every one of those carries a byte
    `BRBF_ASSERT_NOW(a_multi_is_peek, out_valid && !last, data_valid && done_count != '0)

    // a pending register write keeps input words out
    `BRBF_ASSERT_NOW(a_cfg_blocks_in, cfg_valid, in_stall)

endmodule

bind byte_ring_buffer_fifo brbf_checker u_brbf_checker (.*);
